// File: sv/mp2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_pkg: shared types and helpers for the 2-D max pooling stream
// Sample type (signed Q8.8) and the signed maximum used by every cell.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Width of one signed Q8.8 sample.
  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Larger of two signed samples; ties return either, which is the same value.
  function automatic sample_t smax(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: sv/mp2d_row_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_row_cell: one row of the line store
// Holds one earlier image row. The stored sample at the current column is read
// out, folded into the vertical maximum, and handed down to the next row cell
// while this cell takes over the row above it.
// ----------------------------------------------------------------------------
module mp2d_row_cell #(
  parameter int DEPTH = 28,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  mp2d_pkg::sample_t   wr_data,
  input  mp2d_pkg::sample_t   max_in,
  output mp2d_pkg::sample_t   rd_data,
  output mp2d_pkg::sample_t   max_out
);

  mp2d_pkg::sample_t mem [DEPTH];

  // Write the row shifted in from the cell above.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of the column that the accepted item sits in.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Fold this row's sample into the running vertical maximum.
  assign max_out = mp2d_pkg::smax(max_in, rd_data);

endmodule

// File: sv/mp2d_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_col_cell: one column of the pooling window
// Holds the vertical maximum of one earlier column and passes it to its
// neighbor whenever a valid column maximum advances; folds its value into the running window maximum.
// ----------------------------------------------------------------------------
module mp2d_col_cell (
  input  logic                clk,
  input  logic                shift_en,
  input  mp2d_pkg::sample_t   data_in,
  input  mp2d_pkg::sample_t   max_in,
  output mp2d_pkg::sample_t   data_out,
  output mp2d_pkg::sample_t   max_out
);

  // Take the column maximum from the left neighbor.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_out <= data_in;
    end
  end

  // Extend the horizontal maximum with the held column.
  assign max_out = mp2d_pkg::smax(max_in, data_out);

endmodule

// File: sv/max_pooling_2d_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pooling_2d_stream: streaming 2-D max pooling over raster-ordered frames
// Row cells keep earlier image rows and form the vertical maximum per column;
// column cells keep the last column maxima and form the window maximum.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------
//  sample    | in        | sample_valid / sample_stall | sample
//  pooled    | out       | pooled_valid / pooled_stall | pooled_max, last_of_frame
//
//  One item is accepted per cycle while no result is held and stalled; the
//  result of the item that completes its window passes the registered line
//  store read, the vertical maximum register and the output register.
//  Reset clears the position counters and the pipeline valids; the line store
//  is not cleared, since only rows of the current frame are ever used.
//  The whole pipeline halts only while a result is held and stalled.
// ----------------------------------------------------------------------------
module max_pooling_2d_stream #(
  parameter int IMAGE_WIDTH  = 28,
  parameter int IMAGE_HEIGHT = 28,
  parameter int WINDOW_ROWS  = 3,
  parameter int WINDOW_COLS  = 3,
  parameter int STEP         = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic signed [15:0]  sample,
  output logic                pooled_valid,
  input  logic                pooled_stall,
  output logic signed [15:0]  pooled_max,
  output logic                last_of_frame
);

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);
  localparam int PW = (STEP > 1) ? $clog2(STEP) : 1;

  // Position of the bottom-right sample of the last window in a frame.
  localparam int LAST_ROW = (WINDOW_ROWS <= IMAGE_HEIGHT) ?
      (WINDOW_ROWS - 1) + ((IMAGE_HEIGHT - WINDOW_ROWS) / STEP) * STEP : 0;
  localparam int LAST_COL = (WINDOW_COLS <= IMAGE_WIDTH) ?
      (WINDOW_COLS - 1) + ((IMAGE_WIDTH - WINDOW_COLS) / STEP) * STEP : 0;

  logic          en;
  logic          acc;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [PW-1:0] col_phase;
  logic [PW-1:0] row_phase;
  logic          emit;
  logic          last;

  logic              s1_valid;
  mp2d_pkg::sample_t s1_sample;
  logic [CW-1:0]     s1_col;
  logic              s1_emit;
  logic              s1_last;

  logic              s2_valid;
  mp2d_pkg::sample_t s2_vmax;
  logic              s2_emit;
  logic              s2_last;

  mp2d_pkg::sample_t pass  [WINDOW_ROWS];
  mp2d_pkg::sample_t vmax  [WINDOW_ROWS];
  mp2d_pkg::sample_t hdata [WINDOW_COLS];
  mp2d_pkg::sample_t hmax  [WINDOW_COLS];

  // The pipeline advances unless a finished result is held back.
  assign en           = !(pooled_valid && pooled_stall);
  assign sample_stall = !en;
  assign acc          = sample_valid && en;

  // Window completion for the item now entering.
  assign emit = (32'(row_count) >= 32'(WINDOW_ROWS - 1)) &&
                (32'(col_count) >= 32'(WINDOW_COLS - 1)) &&
                (row_phase == '0) && (col_phase == '0);
  assign last = (32'(row_count) == 32'(LAST_ROW)) && (32'(col_count) == 32'(LAST_COL));

  // Raster position counters and stride phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      col_phase <= '0;
      row_phase <= '0;
    end else if (acc) begin
      if (col_count == CW'(IMAGE_WIDTH - 1)) begin
        col_count <= '0;
        col_phase <= '0;
        if (row_count == RW'(IMAGE_HEIGHT - 1)) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= row_count + RW'(1);
          if (32'(row_count) < 32'(WINDOW_ROWS - 1)) begin
            row_phase <= '0;
          end else if (row_phase == PW'(STEP - 1)) begin
            row_phase <= '0;
          end else begin
            row_phase <= row_phase + PW'(1);
          end
        end
      end else begin
        col_count <= col_count + CW'(1);
        if (32'(col_count) < 32'(WINDOW_COLS - 1)) begin
          col_phase <= '0;
        end else if (col_phase == PW'(STEP - 1)) begin
          col_phase <= '0;
        end else begin
          col_phase <= col_phase + PW'(1);
        end
      end
    end
  end

  // Stage 1: the item waits for the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample <= sample;
      s1_col    <= col_count;
      s1_emit   <= emit;
      s1_last   <= last;
    end
  end

  // Row cells: vertical maximum over the current and earlier rows.
  assign pass[0] = s1_sample;
  assign vmax[0] = s1_sample;

  for (genvar k = 0; k < WINDOW_ROWS - 1; k++) begin : g_row
    mp2d_row_cell #(
      .DEPTH (IMAGE_WIDTH),
      .AW    (CW)
    ) u_row (
      .clk     (clk),
      .rd_en   (acc),
      .rd_addr (col_count),
      .wr_en   (s1_valid && en),
      .wr_addr (s1_col),
      .wr_data (pass[k]),
      .max_in  (vmax[k]),
      .rd_data (pass[k+1]),
      .max_out (vmax[k+1])
    );
  end

  // Stage 2: registered column maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vmax <= vmax[WINDOW_ROWS-1];
      s2_emit <= s1_emit;
      s2_last <= s1_last;
    end
  end

  // Column cells: horizontal maximum over the last column maxima.
  assign hdata[0] = s2_vmax;
  assign hmax[0]  = s2_vmax;

  for (genvar i = 0; i < WINDOW_COLS - 1; i++) begin : g_col
    mp2d_col_cell u_col (
      .clk      (clk),
      .shift_en (s2_valid && en),
      .data_in  (hdata[i]),
      .max_in   (hmax[i]),
      .data_out (hdata[i+1]),
      .max_out  (hmax[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pooled_valid <= 1'b0;
    end else if (en) begin
      pooled_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pooled_max    <= hmax[WINDOW_COLS-1];
      last_of_frame <= s2_last;
    end
  end

  // The line store is never read and written at the same column in one cycle.
  assert property (@(posedge clk) disable iff (rst)
    (acc && s1_valid) |-> (col_count != s1_col))
    else $error("line store read and write collide");

  // Counters stay inside the frame.
  assert property (@(posedge clk) disable iff (rst)
    (32'(col_count) < 32'(IMAGE_WIDTH)) && (32'(row_count) < 32'(IMAGE_HEIGHT)))
    else $error("position counter out of range");

  // A window only completes once a full window of rows and columns is in.
  assert property (@(posedge clk) disable iff (rst)
    (acc && emit) |-> ((32'(row_count) >= 32'(WINDOW_ROWS - 1)) &&
                       (32'(col_count) >= 32'(WINDOW_COLS - 1))))
    else $error("window completed too early");

  // While held back, the pipeline does not move.
  assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s2_vmax) && $stable(s1_sample) && $stable(s2_valid)))
    else $error("pipeline moved while halted");

endmodule
